### sv/vector_magnitude_isqrt_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vector magnitude block
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef VECTOR_MAGNITUDE_ISQRT_TOP_ASSERT_SVH
`define VECTOR_MAGNITUDE_ISQRT_TOP_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define VMI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("vector magnitude assertion failed");

// The antecedent implies the consequent in the next cycle.
`define VMI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector magnitude assertion failed");

`endif

### sv/vmi_pkg.sv
// ----------------------------------------------------------------------------
// vmi_pkg
// Fixed field widths and helpers for the vector magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package vmi_pkg;

  localparam int COMP_W = 16;          // component field width
  localparam int ABS_W  = COMP_W + 1;  // magnitude of a component, 32768 fits
  localparam int SQ_W   = 31;          // a square never exceeds 2^30
  localparam int SUM_W  = 32;          // sum of squares never exceeds 2^31
  localparam int MAG_W  = 16;          // result field width
  localparam int FRONT_STAGES = 3;     // absolute value, square, sum

  // Largest possible result: floor(sqrt(2^31)).
  localparam logic [MAG_W-1:0] MAG_MAX = 16'd46340;

  function automatic logic [ABS_W-1:0] abs_comp(input logic [COMP_W-1:0] v);
    logic [ABS_W-1:0] ext;
    ext = {v[COMP_W-1], v};
    return v[COMP_W-1] ? (~ext + 1'b1) : ext;
  endfunction

endpackage

`default_nettype wire

### sv/vector_magnitude_isqrt_top.sv
// Each item passes the absolute value, square and sum registers, then the square root stages.
// Throughput: one item per cycle once busy is low; every stage is a register, and the square root
// spends one pipeline stage per root bit, so nothing is shared between items.
// busy is high only during reset and for the cycle after it; results cannot be held off.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// vector_magnitude_isqrt_top
// Pipelined integer magnitude floor(sqrt(x*x + y*y)) with a non-restoring
// square root that resolves one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vector_magnitude_isqrt_top_assert.svh"

module vector_magnitude_isqrt_top #(
  parameter int ROOT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [vmi_pkg::COMP_W-1:0]  x_component,
  input  wire logic [vmi_pkg::COMP_W-1:0]  y_component,
  output logic                             done,
  output logic [vmi_pkg::MAG_W-1:0]        magnitude
);

  import vmi_pkg::*;

  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int LATENCY  = ROOT_BITS + FRONT_STAGES;

  logic accept;

  // Front end stages.
  logic              v_abs, v_sq, v_rad;
  logic [ABS_W-1:0]  abs_x, abs_y;
  logic [2*ABS_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]   sq_x, sq_y;
  logic [SUM_W-1:0]  sum;
  logic [RAD_BITS-1:0] rad;

  // Square root stages; the last stage keeps only its root and valid bit.
  logic                it_v    [0:ROOT_BITS-1];
  logic [ROOT_BITS-1:0] it_root [0:ROOT_BITS-1];
  logic [REM_BITS-1:0] it_rem  [0:ROOT_BITS-2];
  logic                it_neg  [0:ROOT_BITS-2];
  logic [RAD_BITS-1:0] it_rad  [0:ROOT_BITS-2];

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_abs <= 1'b0;
      v_sq  <= 1'b0;
      v_rad <= 1'b0;
    end else begin
      v_abs <= accept;
      v_sq  <= v_abs;
      v_rad <= v_sq;
    end
  end

  assign prod_x = abs_x * abs_x;
  assign prod_y = abs_y * abs_y;
  assign sum    = SUM_W'(sq_x) + SUM_W'(sq_y);

  always_ff @(posedge clk) begin
    abs_x <= abs_comp(x_component);
    abs_y <= abs_comp(y_component);
    sq_x  <= prod_x[SQ_W-1:0];
    sq_y  <= prod_y[SQ_W-1:0];
    // A narrow root keeps only the low bits of the sum, so large vectors wrap.
    rad   <= sum[RAD_BITS-1:0];
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_it
    logic [RAD_BITS-1:0]  rad_in;
    logic [REM_BITS-1:0]  rem_in, trial, shifted, rem_new;
    logic [ROOT_BITS-1:0] root_in;
    logic                 neg_in, vld_in;

    if (k == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign neg_in  = 1'b0;
      assign vld_in  = v_rad;
    end else begin : g_rest
      assign rad_in  = it_rad[k-1];
      assign rem_in  = it_rem[k-1];
      assign root_in = it_root[k-1];
      assign neg_in  = it_neg[k-1];
      assign vld_in  = it_v[k-1];
    end

    // After a negative remainder the trial ends in 11 and is added back in.
    assign trial   = {root_in, neg_in, 1'b1};
    assign shifted = {rem_in[REM_BITS-3:0], rad_in[RAD_BITS-1 -: 2]};
    assign rem_new = neg_in ? (shifted + trial) : (shifted - trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        it_v[k] <= 1'b0;
      end else begin
        it_v[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      it_root[k] <= {root_in[ROOT_BITS-2:0], ~rem_new[REM_BITS-1]};
    end

    if (k < ROOT_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        it_rem[k] <= rem_new;
        it_neg[k] <= rem_new[REM_BITS-1];
        it_rad[k] <= {rad_in[RAD_BITS-3:0], 2'b00};
      end
    end
  end

  assign done      = it_v[ROOT_BITS-1];
  assign magnitude = MAG_W'(it_root[ROOT_BITS-1]);

  // Every accepted item comes out on done after the front end and square root stages, and only then.
  `VMI_ASSERT_IMPLY(a_item_out, accept, ##LATENCY done)
  `VMI_ASSERT_IMPLY(a_no_stray, done, $past(accept, LATENCY))
  `VMI_ASSERT_IMPLY(a_mag_range, done, (magnitude <= MAG_MAX))
  `VMI_ASSERT_NEXT(a_ready_after_reset, !rst, !busy)

endmodule

`default_nettype wire
